FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each check is disabled while the asynchronous reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/ipc_pkg.sv
`timescale 1ns / 1ps

package ipc_pkg;

    // Field widths.
    localparam int NUM_W  = 16;
    localparam int FUNC_W = 3;
    localparam int CNT_W  = 8;

    // Trial divisors run from 1 up to one past the integer square root.
    localparam int CAND_W = NUM_W / 2 + 1;

    // The sum of all divisors stays below five times the number.
    localparam int SUM_W  = NUM_W + 4;

    // Bit-serial divider step count.
    localparam int STEP_W = $clog2(NUM_W + 1);

    // Fibonacci terms are tracked one bit wider than the number.
    localparam int FIB_W  = NUM_W + 1;

    localparam int unsigned LIMIT_DEFAULT = 65535;

    // Property selector codes.
    localparam logic [FUNC_W-1:0] FUNC_PRIME   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIB     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SQUARE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_EVEN    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PERFECT = 3'd4;

    typedef struct packed {
        logic              go;
        logic [NUM_W-1:0]  dividend;
        logic [CAND_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quotient;
        logic [CAND_W-1:0] remainder;
    } div_res_t;

    typedef struct packed {
        logic             go;
        logic [NUM_W-1:0] number;
    } fib_cmd_t;

    typedef struct packed {
        logic active;
        logic hit;
    } fib_stat_t;

endpackage

FILE: sv/ipc_divider.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipc_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  ipc_pkg::div_cmd_t cmd,
    output ipc_pkg::div_res_t res
);
    import ipc_pkg::*;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of shift_reg while quotient bits shift in at the bottom.
    logic [NUM_W-1:0]  shift_reg, shift_next;
    logic [CAND_W-1:0] rem_reg, rem_next;
    logic [CAND_W-1:0] divisor_reg, divisor_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;

    logic [CAND_W:0]   partial;
    logic              fits;

    always_comb
    begin
        partial = {rem_reg, shift_reg[NUM_W-1]};
        fits    = (partial >= {1'b0, divisor_reg});

        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        done_next    = 1'b0;

        if (cmd.go)
        begin
            shift_next   = cmd.dividend;
            rem_next     = '0;
            divisor_next = cmd.divisor;
            step_next    = STEP_W'(NUM_W);
        end
        else if (step_reg != '0)
        begin
            shift_next = {shift_reg[NUM_W-2:0], fits};
            rem_next   = fits ? CAND_W'(partial - {1'b0, divisor_reg})
                              : partial[CAND_W-1:0];
            step_next  = step_reg - 1'b1;
            done_next  = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = shift_reg;
    assign res.remainder = rem_reg;

    `ASSERT_IMP(a_step_bound, clk, rst_n, 1'b1, step_reg <= STEP_W'(NUM_W))
    `ASSERT_NXT(a_go_loads, clk, rst_n, cmd.go, step_reg == STEP_W'(NUM_W))
    `ASSERT_IMP(a_rem_below, clk, rst_n, done_reg && (divisor_reg != '0),
                rem_reg < divisor_reg)

endmodule

FILE: sv/ipc_fib.sv
`timescale 1ns / 1ps

module ipc_fib (
    input  logic               clk,
    input  logic               rst_n,
    input  ipc_pkg::fib_cmd_t  cmd,
    output ipc_pkg::fib_stat_t stat
);
    import ipc_pkg::*;

    // Walks the Fibonacci sequence one term per cycle until it meets or
    // passes the number.
    logic [FIB_W-1:0] a_reg, a_next;
    logic [FIB_W-1:0] b_reg, b_next;
    logic [NUM_W-1:0] n_reg, n_next;
    logic             active_reg, active_next;
    logic             hit_reg, hit_next;

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        n_next      = n_reg;
        active_next = active_reg;
        hit_next    = hit_reg;

        if (cmd.go)
        begin
            a_next      = '0;
            b_next      = FIB_W'(1);
            n_next      = cmd.number;
            active_next = 1'b1;
            hit_next    = 1'b0;
        end
        else if (active_reg)
        begin
            if (a_reg == {1'b0, n_reg})
            begin
                hit_next    = 1'b1;
                active_next = 1'b0;
            end
            else if (a_reg > {1'b0, n_reg})
            begin
                active_next = 1'b0;
            end
            else
            begin
                a_next = b_reg;
                b_next = FIB_W'(a_reg + b_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            hit_reg    <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        n_reg <= n_next;
    end

    assign stat.active = active_reg;
    assign stat.hit    = hit_reg;

endmodule

FILE: sv/integer_property_classifier.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Classifies one 16-bit whole number per command. Raise start with number and
// func while busy is low; the word is taken at that clock edge and busy rises.
// When the work is finished, done is high for exactly one cycle with answer,
// divisor_total and out_of_range valid in that same cycle. The receiver cannot
// stall the block, so the result must be captured in that cycle; busy is
// already low then and a new word may be started at the same edge. The divisor
// count comes from trial division by every candidate i with i*i <= number, and
// each candidate goes through a bit-serial divider that resolves one quotient
// bit per cycle. Each candidate passes through a launch, 16 divide steps and
// a check, and an item tries floor(sqrt(number)) + 1 candidates in turn. A
// number above LIMIT skips the division and goes straight to the wrap-up
// state, where it is answered with out_of_range set. A Fibonacci walk runs
// alongside the division and always finishes first. Func codes 5 to 7 give
// an answer of 0 with the divisor count still reported.
module integer_property_classifier #(
    parameter int unsigned LIMIT = ipc_pkg::LIMIT_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ipc_pkg::NUM_W-1:0]   number,
    input  logic [ipc_pkg::FUNC_W-1:0]  func,
    output logic                        done,
    output logic                        answer,
    output logic [ipc_pkg::CNT_W-1:0]   divisor_total,
    output logic                        out_of_range
);
    import ipc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_WRAP
    } state_t;

    state_t            state_reg, state_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [CAND_W-1:0] cand_reg, cand_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sigma_reg, sigma_next;
    logic              square_reg, square_next;
    logic              oor_reg, oor_next;
    logic              done_reg, done_next;
    logic              answer_reg, answer_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              oor_out_reg, oor_out_next;

    div_cmd_t  div_cmd;
    div_res_t  div_res;
    fib_cmd_t  fib_cmd;
    fib_stat_t fib_stat;

    logic              accept;
    logic [NUM_W-1:0]  cand_wide;
    logic              pair_equal;
    logic              past_root;
    logic [NUM_W:0]    pair_sum;
    logic              prop;

    assign accept = start && (state_reg == ST_IDLE);

    // The divider is launched once per candidate.
    assign div_cmd.go       = (state_reg == ST_LAUNCH);
    assign div_cmd.dividend = num_reg;
    assign div_cmd.divisor  = cand_reg;

    assign fib_cmd.go     = accept;
    assign fib_cmd.number = number;

    ipc_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .res   (div_res)
    );

    ipc_fib u_fib (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fib_cmd),
        .stat  (fib_stat)
    );

    // The candidate i satisfies i*i <= n exactly when i <= n / i, so the
    // quotient itself tells when the search has passed the square root.
    assign cand_wide  = NUM_W'(cand_reg);
    assign pair_equal = (div_res.quotient == cand_wide);
    assign past_root  = (div_res.quotient < cand_wide);
    assign pair_sum   = pair_equal ? (NUM_W + 1)'(cand_wide)
                                   : (NUM_W + 1)'(div_res.quotient) + (NUM_W + 1)'(cand_wide);

    always_comb
    begin
        case (func_reg)
            FUNC_PRIME:   prop = (cnt_reg == CNT_W'(2));
            FUNC_FIB:     prop = fib_stat.hit;
            FUNC_SQUARE:  prop = square_reg;
            FUNC_EVEN:    prop = !num_reg[0];
            FUNC_PERFECT: prop = (num_reg >= NUM_W'(2))
                                 && (sigma_reg == SUM_W'({num_reg, 1'b0}));
            default:      prop = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        num_next     = num_reg;
        func_next    = func_reg;
        cand_next    = cand_reg;
        cnt_next     = cnt_reg;
        sigma_next   = sigma_reg;
        square_next  = square_reg;
        oor_next     = oor_reg;
        done_next    = 1'b0;
        answer_next  = answer_reg;
        total_next   = total_reg;
        oor_out_next = oor_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    num_next    = number;
                    func_next   = func;
                    cand_next   = CAND_W'(1);
                    cnt_next    = '0;
                    sigma_next  = '0;
                    square_next = (number == '0);
                    oor_next    = (number > NUM_W'(LIMIT));
                    state_next  = (number > NUM_W'(LIMIT)) ? ST_WRAP : ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_res.done)
                begin
                    if (past_root)
                    begin
                        state_next = ST_WRAP;
                    end
                    else
                    begin
                        if (div_res.remainder == '0)
                        begin
                            cnt_next   = cnt_reg + (pair_equal ? CNT_W'(1) : CNT_W'(2));
                            sigma_next = sigma_reg + SUM_W'(pair_sum);
                            if (pair_equal)
                            begin
                                square_next = 1'b1;
                            end
                        end
                        cand_next  = cand_reg + 1'b1;
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_WRAP:
            begin
                if (oor_reg)
                begin
                    done_next    = 1'b1;
                    answer_next  = 1'b0;
                    total_next   = '0;
                    oor_out_next = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (!fib_stat.active)
                begin
                    done_next    = 1'b1;
                    answer_next  = prop;
                    total_next   = cnt_reg;
                    oor_out_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            num_reg     <= '0;
            func_reg    <= '0;
            cand_reg    <= '0;
            cnt_reg     <= '0;
            sigma_reg   <= '0;
            square_reg  <= 1'b0;
            oor_reg     <= 1'b0;
            done_reg    <= 1'b0;
            answer_reg  <= 1'b0;
            total_reg   <= '0;
            oor_out_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            num_reg     <= num_next;
            func_reg    <= func_next;
            cand_reg    <= cand_next;
            cnt_reg     <= cnt_next;
            sigma_reg   <= sigma_next;
            square_reg  <= square_next;
            oor_reg     <= oor_next;
            done_reg    <= done_next;
            answer_reg  <= answer_next;
            total_reg   <= total_next;
            oor_out_reg <= oor_out_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign answer        = answer_reg;
    assign divisor_total = total_reg;
    assign out_of_range  = oor_out_reg;

    `ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_IMP(a_oor_clear, clk, rst_n, done && out_of_range,
                !answer && (divisor_total == '0))
    `ASSERT_IMP(a_prime_count, clk, rst_n,
                done && !out_of_range && (func_reg == FUNC_PRIME),
                answer == (divisor_total == CNT_W'(2)))

endmodule
